[sv/spd_pkg.sv]
// ----------------------------------------------------------------------------
// spd_pkg: shared definitions for the gain-scheduled PD steering core
// Field widths, register indexes, fixed-point constants and the ring
// memory request type used by the core and its sample ring.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

  // Moving-average depth and gain-schedule split point.
  localparam int AVG_DEPTH   = 10;
  localparam int SPEED_SPLIT = 180;

  // Field widths.
  localparam int DIFF_W     = 13;
  localparam int GYRO_W     = 16;
  localparam int SPEED_W    = 12;
  localparam int CMD_W      = 32;
  localparam int GAIN_W     = 16;
  localparam int BLEND_W    = 9;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Ring addressing and running sum.
  localparam int RING_AW = $clog2(AVG_DEPTH);
  localparam int SUM_W   = DIFF_W + $clog2(AVG_DEPTH);

  // Divide by the depth through a reciprocal multiply. The shift is wide
  // enough that the truncated quotient is exact for every sum magnitude.
  localparam int RECIP_SHIFT = SUM_W + $clog2(AVG_DEPTH);
  localparam int RECIP       = (2 ** RECIP_SHIFT + AVG_DEPTH - 1) / AVG_DEPTH;

  // Datapath widths.
  localparam int AVG_W       = DIFF_W + 1;
  localparam int ERR_W       = DIFF_W + 1;
  localparam int CHANGE_W    = ERR_W + 1;
  localparam int FC_W        = 24;
  localparam int GDIFF_W     = GYRO_W + 1;
  localparam int SCALE_SHIFT = 9;
  localparam int SCALE_W     = SCALE_SHIFT + 2;

  // Low-pass coefficients, Q.8: new weight 38, old weight 218.
  localparam int LP_SHIFT  = 8;
  localparam int LP_NEW    = 38;
  localparam int LP_OLD    = 218;
  localparam int LP_NEW_Q8 = LP_NEW * (2 ** LP_SHIFT);
  localparam int LP_W      = FC_W + LP_SHIFT + 1;

  // Shared multiplier and accumulator widths.
  localparam int MUL_A_W = SUM_W + 2;
  localparam int MUL_B_W = FC_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W;
  localparam int Q8_SHIFT  = 8;
  localparam int OUT_SHIFT = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN_LOW     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN_HIGH    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN_LOW  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN_HIGH = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ROAD_GAIN_LOW  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ROAD_GAIN_HIGH = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_BLEND          = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET    = CFG_IDX_W'(7);

  localparam int GYRO_OFFSET_RESET = 209;

  // One access to the sample ring.
  typedef struct packed {
    logic                     rd_en;
    logic                     wr_en;
    logic [RING_AW-1:0]       addr;
    logic signed [DIFF_W-1:0] wdata;
  } spd_ring_req_t;

endpackage

`default_nettype wire

[sv/spd_intf.sv]
// ----------------------------------------------------------------------------
// spd_intf: channel interfaces of the steering core
// Tick channel, command channel and configuration write channel, each with
// valid, ready and its payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface spd_tick_if;
  import spd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [DIFF_W-1:0]   diff_sample;
  logic signed [GYRO_W-1:0]   gyro_sample;
  logic        [SPEED_W-1:0]  speed;
  modport source (output valid, diff_sample, gyro_sample, speed, input ready);
  modport sink   (input valid, diff_sample, gyro_sample, speed, output ready);
endinterface

interface spd_cmd_if;
  import spd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CMD_W-1:0]  steer_command;
  modport source (output valid, steer_command, input ready);
  modport sink   (input valid, steer_command, output ready);
endinterface

interface spd_cfg_if;
  import spd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/spd_ring_mem.sv]
// ----------------------------------------------------------------------------
// spd_ring_mem: moving-average sample ring
// Synchronous memory with registered read. Each entry carries a
// valid bit cleared by reset; an entry never written reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_ring_mem (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire spd_pkg::spd_ring_req_t        req,
  output logic signed [spd_pkg::DIFF_W-1:0]  rdata
);
  import spd_pkg::*;

  logic signed [DIFF_W-1:0] mem [AVG_DEPTH];
  logic [AVG_DEPTH-1:0]     valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= valid[req.addr] ? mem[req.addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.addr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[sv/steering_pd_gain_scheduled_core.sv]
// ----------------------------------------------------------------------------
// steering_pd_gain_scheduled_core: gain-scheduled PD steering controller
// Moving average of the sensor difference, blended error, low-passed error
// change and a speed-scheduled gain set produce one steering command a tick.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the tick channel is one control tick carrying the
// sensor difference, the raw gyro rate and the speed count. Each tick gives
// exactly one transaction on the command channel with the saturated 32-bit
// steering command.
// Gains, blend and gyro offset are written through the configuration
// channel, which is always ready; write it only while no tick is in flight.
// Indexes beyond the register list are ignored.
// The tick channel drops ready once a tick is accepted and raises it again
// as the command is loaded into the output register. That span is set by
// the read-modify-write of the sample ring memory and by five products that
// pass one after another through the single shared multiplier.
// If the receiver stalls, the command waits in the output register; the
// next tick is accepted meanwhile and its command waits until the held one
// is taken.
// Reset clears the ring (through per-entry valid bits), the running sum,
// the ring position and the filter state, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module steering_pd_gain_scheduled_core (
  input  wire logic  clk,
  input  wire logic  rst,
  spd_tick_if.sink   tick,
  spd_cmd_if.source  command,
  spd_cfg_if.sink    cfg
);
  import spd_pkg::*;

  // Sequencer states: one step per multiplier use, roughly.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_RECIP,
    S_AVG,
    S_SCALE,
    S_ERR,
    S_PG,
    S_DR,
    S_ACC,
    S_OUT
  } state_t;

  localparam logic signed [MUL_A_W-1:0] RECIP_A = MUL_A_W'(RECIP);
  localparam logic [SPEED_W-1:0]        SPLIT   = SPEED_W'(SPEED_SPLIT);
  localparam logic [RING_AW-1:0]        LAST_IX = RING_AW'(AVG_DEPTH - 1);
  localparam int                        XW      = ACC_W - OUT_SHIFT + CMD_W;

  // Configuration registers.
  logic signed [GAIN_W-1:0]  p_gain_low, p_gain_high;
  logic signed [GAIN_W-1:0]  gyro_gain_low, gyro_gain_high;
  logic signed [GAIN_W-1:0]  road_gain_low, road_gain_high;
  logic        [BLEND_W-1:0] blend;
  logic signed [GYRO_W-1:0]  gyro_offset;

  // Controller state.
  state_t                     state;
  logic [RING_AW-1:0]         ring_index;
  logic signed [SUM_W-1:0]    ring_sum;
  logic signed [ERR_W-1:0]    prev_error;
  logic signed [FC_W-1:0]     filtered_change;

  // Per-tick working registers.
  logic signed [DIFF_W-1:0]   sample;
  logic signed [GDIFF_W-1:0]  gdiff;
  logic                       high_speed;
  logic signed [AVG_W-1:0]    avg;
  logic signed [CHANGE_W-1:0] change;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic                       cmd_valid;
  logic signed [CMD_W-1:0]    cmd;

  // Ring memory.
  spd_ring_req_t              ring_req;
  logic signed [DIFF_W-1:0]   ring_rdata;

  // Combinational datapath.
  logic                       tick_accept;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic [SUM_W-1:0]           sum_abs;
  logic [AVG_W-1:0]           quot;
  logic signed [PROD_W-1:0]   err_biased;
  logic signed [ERR_W-1:0]    err;
  logic signed [LP_W-1:0]     lp_sum;
  logic signed [ACC_W-1:0]    prod_q8;
  logic signed [XW-1:0]       cmd_wide;
  logic signed [CMD_W-1:0]    cmd_sat;
  logic [SCALE_SHIFT:0]       scale;
  logic signed [GAIN_W-1:0]   pg, dg, dr;

  assign tick.ready            = (state == S_IDLE);
  assign tick_accept           = tick.valid && tick.ready;
  assign cfg.ready             = 1'b1;
  assign command.valid         = cmd_valid;
  assign command.steer_command = cmd;

  // Register file. The user must write only while the core is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain_low     <= '0;
      p_gain_high    <= '0;
      gyro_gain_low  <= '0;
      gyro_gain_high <= '0;
      road_gain_low  <= '0;
      road_gain_high <= '0;
      blend          <= '0;
      gyro_offset    <= GYRO_W'(GYRO_OFFSET_RESET);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_P_GAIN_LOW:     p_gain_low     <= cfg.data;
        REG_P_GAIN_HIGH:    p_gain_high    <= cfg.data;
        REG_GYRO_GAIN_LOW:  gyro_gain_low  <= cfg.data;
        REG_GYRO_GAIN_HIGH: gyro_gain_high <= cfg.data;
        REG_ROAD_GAIN_LOW:  road_gain_low  <= cfg.data;
        REG_ROAD_GAIN_HIGH: road_gain_high <= cfg.data;
        REG_BLEND:          blend          <= cfg.data[BLEND_W-1:0];
        REG_GYRO_OFFSET:    gyro_offset    <= cfg.data;
        default: ;
      endcase
    end
  end

  // The ring entry is read when the tick is accepted and written back in the
  // next cycle, in S_SUM. The next read cannot start before the core is idle
  // again, so a read never overlaps the write to the same entry.
  always_comb begin
    ring_req.rd_en = tick_accept;
    ring_req.wr_en = (state == S_SUM);
    ring_req.addr  = ring_index;
    ring_req.wdata = sample;
  end

  spd_ring_mem u_ring (
    .clk   (clk),
    .rst   (rst),
    .req   (ring_req),
    .rdata (ring_rdata)
  );

  // Gain set picked by the speed of the current tick.
  always_comb begin
    pg = high_speed ? p_gain_high    : p_gain_low;
    dg = high_speed ? gyro_gain_high : gyro_gain_low;
    dr = high_speed ? road_gain_high : road_gain_low;
  end

  // Average: the sum magnitude times the reciprocal of the depth gives the
  // quotient truncated toward zero; the sign is put back afterwards.
  assign sum_abs = ring_sum[SUM_W-1] ? SUM_W'(-ring_sum) : SUM_W'(ring_sum);
  assign quot    = prod[RECIP_SHIFT +: AVG_W];

  // Error scale is one plus the blend over 512, in units of 1/512.
  assign scale = (SCALE_SHIFT + 1)'(2 ** SCALE_SHIFT) + (SCALE_SHIFT + 1)'(blend);

  // Error: the scaled average divided by 512, truncated toward zero.
  assign err_biased = prod + (prod[PROD_W-1] ? PROD_W'(2 ** SCALE_SHIFT - 1) : '0);
  assign err        = err_biased[SCALE_SHIFT +: ERR_W];

  // Low-pass of the error change in Q.8; the bit select floors.
  assign lp_sum = LP_W'(filtered_change) * LP_W'(LP_OLD)
                + LP_W'(change) * LP_W'(LP_NEW_Q8);

  // Products that enter the accumulator pre-scaled by 256.
  assign prod_q8 = {prod[PROD_W-Q8_SHIFT-1:0], {Q8_SHIFT{1'b0}}};

  // Command: floor of the sum over 65536, clamped to the signed 32-bit range.
  always_comb begin
    cmd_wide = XW'($signed(acc[ACC_W-1:OUT_SHIFT]));
    if (cmd_wide > XW'(2 ** (CMD_W - 1) - 1)) begin
      cmd_sat = {1'b0, {(CMD_W-1){1'b1}}};
    end else if (cmd_wide < $signed({{(XW-CMD_W+1){1'b1}}, {(CMD_W-1){1'b0}}})) begin
      cmd_sat = {1'b1, {(CMD_W-1){1'b0}}};
    end else begin
      cmd_sat = cmd_wide[CMD_W-1:0];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_RECIP: begin
        mul_a = RECIP_A;
        mul_b = MUL_B_W'($signed({1'b0, sum_abs}));
      end
      S_SCALE: begin
        mul_a = MUL_A_W'($signed({1'b0, scale}));
        mul_b = MUL_B_W'(avg);
      end
      S_ERR: begin
        mul_a = MUL_A_W'(gdiff);
        mul_b = MUL_B_W'(dg);
      end
      S_PG: begin
        mul_a = MUL_A_W'(pg);
        mul_b = MUL_B_W'(prev_error);
      end
      S_DR: begin
        mul_a = MUL_A_W'(dr);
        mul_b = MUL_B_W'(filtered_change);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Sequencer with the controller state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ring_index      <= '0;
      ring_sum        <= '0;
      prev_error      <= '0;
      filtered_change <= '0;
      cmd_valid       <= 1'b0;
    end else begin
      // In S_OUT the output register is reloaded by the state step below.
      if (cmd_valid && command.ready && state != S_OUT) begin
        cmd_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (tick_accept) begin
            sample     <= tick.diff_sample;
            gdiff      <= GDIFF_W'(tick.gyro_sample) - GDIFF_W'(gyro_offset);
            high_speed <= (tick.speed >= SPLIT);
            state      <= S_SUM;
          end
        end
        S_SUM: begin
          ring_sum   <= ring_sum - SUM_W'(ring_rdata) + SUM_W'(sample);
          ring_index <= (ring_index == LAST_IX) ? '0 : ring_index + 1'b1;
          state      <= S_RECIP;
        end
        S_RECIP: begin
          state <= S_AVG;
        end
        S_AVG: begin
          avg   <= ring_sum[SUM_W-1] ? -$signed(quot) : $signed(quot);
          state <= S_SCALE;
        end
        S_SCALE: begin
          change <= CHANGE_W'(avg) - CHANGE_W'(prev_error);
          state  <= S_ERR;
        end
        S_ERR: begin
          prev_error      <= err;
          filtered_change <= lp_sum[LP_SHIFT +: FC_W];
          state           <= S_PG;
        end
        S_PG: begin
          acc   <= prod_q8;
          state <= S_DR;
        end
        S_DR: begin
          acc   <= acc + prod_q8;
          state <= S_ACC;
        end
        S_ACC: begin
          acc   <= acc + prod;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!cmd_valid || command.ready) begin
            cmd       <= cmd_sat;
            cmd_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/spd_checker.sv]
// ----------------------------------------------------------------------------
// spd_checker: port-level checks for the steering core
// Watches the tick and command channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        tick_valid,
  input wire logic                        tick_ready,
  input wire logic                        cmd_valid,
  input wire logic                        cmd_ready,
  input wire logic [spd_pkg::CMD_W-1:0]   steer_command
);

  // A stalled command stays offered.
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid)
    else $error("command dropped while stalled");

  // A stalled command keeps its value.
  a_cmd_stable: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> $stable(steer_command))
    else $error("command changed while stalled");

  // Ticks are processed one at a time.
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick accepted while another is in flight");

  // No command can appear in the cycle right after a tick is taken.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !$rose(cmd_valid))
    else $error("command appeared too early");

  // Reset leaves the core empty and ready for a tick.
  a_reset: assert property (@(posedge clk)
    rst |=> !cmd_valid && tick_ready)
    else $error("core not idle after reset");

endmodule

bind steering_pd_gain_scheduled_core spd_checker u_spd_checker (
  .clk           (clk),
  .rst           (rst),
  .tick_valid    (tick.valid),
  .tick_ready    (tick.ready),
  .cmd_valid     (command.valid),
  .cmd_ready     (command.ready),
  .steer_command (command.steer_command)
);

`default_nettype wire
